// ===== design/heightmap_max_depositor_defines.svh =====
// Assertion macros for the height map depositor.
`ifndef HEIGHTMAP_MAX_DEPOSITOR_DEFINES_SVH
`define HEIGHTMAP_MAX_DEPOSITOR_DEFINES_SVH
`ifndef SYNTH
`define HMD_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define HMD_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define HMD_ASSERT_IMP(label, clk, rst, a, c)
`define HMD_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== design/hmd_pkg.sv =====
// Package with types, codes and helpers of the height map depositor.
`default_nettype none
package hmd_pkg;
  localparam int DefMaxColumns = 256;
  localparam int DefMaxRows = 256;
  localparam int GridCells = 65536;
  localparam int IdxW = 16;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_DEPOSIT = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_MAP_WIDTH = 3'd2;
  localparam logic [2:0] REG_MAP_HEIGHT = 3'd3;
  localparam logic [2:0] REG_COLUMNS = 3'd4;
  localparam logic [2:0] REG_ROWS = 3'd5;
  localparam logic [2:0] REG_FLOOR = 3'd6;

  typedef struct packed {
    logic [1:0] func;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [15:0] read_cell;
  } in_item_t;

  typedef struct packed {
    logic in_map;
    logic [15:0] cell_index;
    logic signed [31:0] cell_height;
  } out_item_t;

  // Classified operation handed from the front to the back.
  typedef struct packed {
    logic [1:0] func;
    logic in_map;
    logic [15:0] cell_idx;
    logic signed [31:0] value;
  } op_t;
endpackage
`default_nettype wire

// ===== design/hmd_front.sv =====
// Front end: accepts items, maps deposit points to cells with a serial divider.
`default_nettype none
module hmd_front #(
  parameter int MAX_COLUMNS = hmd_pkg::DefMaxColumns,
  parameter int MAX_ROWS = hmd_pkg::DefMaxRows
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic valid,
  output logic stall,
  input wire hmd_pkg::in_item_t item,
  input wire logic signed [31:0] origin_x,
  input wire logic signed [31:0] origin_y,
  input wire logic [30:0] map_width,
  input wire logic [30:0] map_height,
  input wire logic [8:0] columns,
  input wire logic [8:0] rows,
  input wire logic signed [31:0] floor_height,
  output logic op_valid,
  input wire logic op_full,
  output hmd_pkg::op_t op
);
  import hmd_pkg::*;
  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int NW = (CW > RW) ? CW : RW;
  // Dividend is d*count, at most 31+NW bits; quotient fits in NW bits after clamp
  // but for a point in the map the raw quotient of d*count/extent is at most count.
  localparam int DW = 31 + NW;
  localparam int STEPS = NW + 1;
  localparam int SW = $clog2(DW + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_MUL = 4'b0010, S_DIV = 4'b0100, S_OUT = 4'b1000
  } state_t;
  state_t state;

  logic [NW-1:0] cols, rws;
  always_comb begin
    if (columns == 9'd0) cols = NW'(1);
    else if (32'(columns) > 32'(MAX_COLUMNS)) cols = NW'(MAX_COLUMNS);
    else cols = NW'(columns);
    if (rows == 9'd0) rws = NW'(1);
    else if (32'(rows) > 32'(MAX_ROWS)) rws = NW'(MAX_ROWS);
    else rws = NW'(rows);
  end

  logic signed [32:0] dx, dy;
  assign dx = 33'(item.point_x) - 33'(origin_x);
  assign dy = 33'(origin_y) - 33'(item.point_y);

  in_item_t held;
  logic signed [32:0] held_dy;
  logic axis;           // 0 x, 1 y
  logic ok;
  logic [30:0] dval;
  logic [DW-1:0] prod;
  logic [DW:0] rem;
  logic [NW:0] quo;
  logic [SW-1:0] step;
  logic [NW-1:0] col;
  logic [NW-1:0] cnt;
  logic [30:0] ext;

  // The y offset of the item being worked on; the input port has moved on by then.
  assign held_dy = 33'(origin_y) - 33'(held.point_y);

  assign cnt = axis ? rws : cols;
  assign ext = axis ? map_height : map_width;

  logic [NW:0] qcl;
  assign qcl = (quo > (NW+1)'(cnt - NW'(1))) ? (NW+1)'(cnt - NW'(1)) : quo;

  logic [2*NW-1:0] idx_full;
  assign idx_full = (2*NW)'(qcl[NW-1:0]) * (2*NW)'(cols) + (2*NW)'(col);

  assign stall = (state != S_IDLE) || op_full;

  // Long division of d*count by extent, bit-serial; quotient bits are kept from the last
  // NW+1 steps only. prod shifts the dividend out at the top and rem the running remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op_valid <= 1'b0;
    end else begin
      op_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (valid && !op_full) begin
            held <= item;
            if (item.func == FUNC_DEPOSIT) begin
              ok <= !dx[32] && !dy[32] && (dx <= 33'(map_width))
                    && (dy <= 33'(map_height));
              axis <= 1'b0;
              dval <= dx[30:0];
              state <= S_MUL;
            end else begin
              op_valid <= 1'b1;
              op.func <= item.func;
              op.in_map <= 1'b0;
              op.cell_idx <= (item.func == FUNC_READ) ? item.read_cell : 16'd0;
              op.value <= (item.func == FUNC_CLEAR) ? floor_height : 32'sd0;
            end
          end
        end
        S_MUL: begin
          prod <= DW'(dval) * DW'(cnt);
          rem <= '0;
          quo <= '0;
          step <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (ext == 31'd0) begin
            quo <= '0;
            state <= S_OUT;
          end else begin
            // Bring down enough bits: process the top bits of prod serially.
            rem <= {rem[DW-1:0], prod[DW-1]};
            prod <= {prod[DW-2:0], 1'b0};
            if (32'(step) >= 32'(DW - STEPS)) begin
              if ({rem[DW-1:0], prod[DW-1]} >= (DW+1)'(ext)) begin
                rem <= {rem[DW-1:0], prod[DW-1]} - (DW+1)'(ext);
                quo <= {quo[NW-1:0], 1'b1};
              end else begin
                quo <= {quo[NW-1:0], 1'b0};
              end
            end
            step <= step + SW'(1);
            if (32'(step) == 32'(DW - 1)) state <= S_OUT;
          end
        end
        default: begin
          if (!axis) begin
            col <= qcl[NW-1:0];
            axis <= 1'b1;
            dval <= held_dy[30:0];
            state <= S_MUL;
          end else begin
            op_valid <= 1'b1;
            op.func <= FUNC_DEPOSIT;
            op.in_map <= ok;
            op.cell_idx <= ok ? idx_full[IdxW-1:0] : 16'd0;
            op.value <= held.point_z;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/hmd_queue.sv =====
// Short queue between the front and the back.
`default_nettype none
module hmd_queue (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire hmd_pkg::op_t push_op,
  output logic full,
  input wire logic pop,
  output logic empty,
  output hmd_pkg::op_t pop_op
);
  import hmd_pkg::*;
  op_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] count;
  assign empty = (count == 3'd0);
  // Leave room for the one item the front may still hand over.
  assign full = (count >= 3'd3);
  assign pop_op = mem[rp];
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) begin
        mem[wp] <= push_op;
        wp <= wp + 2'd1;
      end
      if (pop) rp <= rp + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== design/hmd_back.sv =====
// Back end: grid memory, clear sweep, max update and result register.
`default_nettype none
module hmd_back (
  input wire logic clk,
  input wire logic rst,
  input wire logic op_ready,
  output logic op_pop,
  input wire hmd_pkg::op_t op,
  output logic valid,
  input wire logic stall,
  output hmd_pkg::out_item_t result
);
  import hmd_pkg::*;
  typedef enum logic [4:0] {
    B_IDLE = 5'b00001, B_CLEAR = 5'b00010, B_READ = 5'b00100,
    B_UPD = 5'b01000, B_OUT = 5'b10000
  } bstate_t;
  bstate_t state;
  logic signed [31:0] grid [GridCells];
  logic [IdxW:0] sweep;
  op_t cur;
  logic signed [31:0] rdata;
  logic we;
  logic [IdxW-1:0] waddr;
  logic signed [31:0] wdata;

  assign op_pop = (state == B_IDLE) && op_ready && !valid;

  always_comb begin
    we = 1'b0;
    waddr = cur.cell_idx;
    wdata = cur.value;
    if (state == B_CLEAR) begin
      we = 1'b1;
      waddr = sweep[IdxW-1:0];
    end else if (state == B_UPD && cur.in_map && (cur.value > rdata)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) grid[waddr] <= wdata;
    rdata <= grid[op_pop ? op.cell_idx : cur.cell_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      valid <= 1'b0;
    end else begin
      if (valid && !stall) valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (op_pop) begin
            cur <= op;
            sweep <= '0;
            if (op.func == FUNC_CLEAR) state <= B_CLEAR;
            else if (op.func == FUNC_READ) state <= B_READ;
            else if (op.func == FUNC_DEPOSIT && op.in_map) state <= B_UPD;
            else state <= B_OUT;
          end
        end
        B_CLEAR: begin
          sweep <= sweep + (IdxW+1)'(1);
          if (sweep[IdxW-1:0] == {IdxW{1'b1}}) state <= B_OUT;
        end
        B_READ: begin
          cur.value <= rdata;
          state <= B_OUT;
        end
        B_UPD: begin
          if (!(cur.value > rdata)) cur.value <= rdata;
          state <= B_OUT;
        end
        default: begin
          valid <= 1'b1;
          result.in_map <= cur.in_map;
          result.cell_index <= cur.cell_idx;
          result.cell_height <= (cur.func == FUNC_DEPOSIT && !cur.in_map) ? 32'sd0
                                : cur.value;
          state <= B_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/heightmap_max_depositor.sv =====
// Top level of the height map depositor.
//   channel | valid    | stall     | payload
//   in      | in_valid | in_stall  | in_item (in_item_t)
//   out     | out_valid| out_stall | out_item (out_item_t)
//   cfg     | cfg_we   | -         | cfg_index, cfg_data
// A deposit keeps the front busy after acceptance: per axis a multiply, a bit-serial
// divide of the 31+NW bit dividend and a clamp. Clear and read pass the front from
// its idle state; in the back an op takes its clear, read or update state if any.
// A clear sweeps the 65536-entry grid memory one cell a cycle in the back.
// Reset is synchronous; the grid is undefined until the first clear.
// Either side may stall; a four-entry queue decouples front and back.
`default_nettype none
`include "heightmap_max_depositor_defines.svh"
module heightmap_max_depositor #(
  parameter int MAX_COLUMNS = hmd_pkg::DefMaxColumns,
  parameter int MAX_ROWS = hmd_pkg::DefMaxRows
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  input wire hmd_pkg::in_item_t in_item,
  output logic out_valid,
  input wire logic out_stall,
  output hmd_pkg::out_item_t out_item,
  input wire logic cfg_we,
  input wire logic [2:0] cfg_index,
  input wire logic [31:0] cfg_data
);
  import hmd_pkg::*;
  logic signed [31:0] origin_x, origin_y, floor_height;
  logic [30:0] map_width, map_height;
  logic [8:0] columns, rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      map_width <= 31'd65536;
      map_height <= 31'd65536;
      columns <= 9'd256;
      rows <= 9'd256;
      floor_height <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_MAP_WIDTH: map_width <= cfg_data[30:0];
        REG_MAP_HEIGHT: map_height <= cfg_data[30:0];
        REG_COLUMNS: columns <= cfg_data[8:0];
        REG_ROWS: rows <= cfg_data[8:0];
        REG_FLOOR: floor_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic op_valid, q_full, q_empty, q_pop;
  op_t f_op, q_op;

  hmd_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk, .rst, .valid(in_valid), .stall(in_stall), .item(in_item),
    .origin_x, .origin_y, .map_width, .map_height, .columns, .rows,
    .floor_height, .op_valid, .op_full(q_full), .op(f_op)
  );

  hmd_queue u_queue (
    .clk, .rst, .push(op_valid), .push_op(f_op), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_op(q_op)
  );

  hmd_back u_back (
    .clk, .rst, .op_ready(!q_empty), .op_pop(q_pop), .op(q_op),
    .valid(out_valid), .stall(out_stall), .result(out_item)
  );

  `HMD_ASSERT_IMP(a_pop_nonempty, clk, rst, q_pop, !q_empty)
  `HMD_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_item))
  `HMD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
endmodule
`default_nettype wire
